@@ rtl/core/hahr_pkg.sv @@
`timescale 1ns / 1ps

package hahr_pkg;

  // ring geometry
  localparam int RING_DEPTH = 50;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // field widths
  localparam int ADC_W   = 10;
  localparam int HUM_W   = 7;
  localparam int TOTAL_W = 13;
  localparam int X_W     = 16;

  // calibration h = floor((36*adc + 730) / 301), divide done by reciprocal
  localparam int CAL_MUL   = 36;
  localparam int CAL_ADD   = 730;
  localparam int CAL_DIV   = 301;
  localparam int CAL_SHIFT = 24;
  localparam int CAL_RW    = 16;
  localparam logic [CAL_RW-1:0] CAL_RECIP =
    CAL_RW'((2**CAL_SHIFT + CAL_DIV - 1) / CAL_DIV);
  localparam int CAL_PW = X_W + CAL_RW;

  // mean = floor(total / RING_DEPTH), same trick
  localparam int AVG_SHIFT = 20;
  localparam int AVG_RW    = AVG_SHIFT + 1;
  localparam logic [AVG_RW-1:0] AVG_RECIP =
    AVG_RW'((2**AVG_SHIFT + RING_DEPTH - 1) / RING_DEPTH);
  localparam int AVG_PW = TOTAL_W + AVG_RW;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 1'd1;

  localparam logic [HUM_W-1:0] LOW_THRESHOLD_RST  = 7'd25;
  localparam logic [HUM_W-1:0] HIGH_THRESHOLD_RST = 7'd50;

  // ring write port
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [HUM_W-1:0]  data;
  } ring_wr_t;

endpackage

@@ rtl/core/hahr_ring.sv @@
`timescale 1ns / 1ps

module hahr_ring (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [hahr_pkg::SLOT_W-1:0] rd_slot,
  output logic [hahr_pkg::HUM_W-1:0]  rd_data,
  input  hahr_pkg::ring_wr_t          wr
);

  logic [hahr_pkg::HUM_W-1:0] mem [hahr_pkg::RING_DEPTH];
  logic [hahr_pkg::HUM_W-1:0] q_r;
  logic [hahr_pkg::RING_DEPTH-1:0] valid_r;
  logic vld_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot] <= wr.data;
    end
    if (rd_en) begin
      q_r <= mem[rd_slot];
    end
  end

  // per-entry valid bits stand in for clearing the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.slot] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= valid_r[rd_slot];
      end
    end
  end

  assign rd_data = vld_q_r ? q_r : '0;

endmodule

@@ rtl/core/humidity_average_hysteresis_relay.sv @@
`timescale 1ns / 1ps
// an accepted sample beat is registered through stages 1 to 4 and the output register
// throughput: one sample per cycle while the pipeline is not held, the ring ram has one read and one write port
// the whole pipeline holds only when the last stage has a result and the output
// register is full and not taken
// reset: synchronous, active low; ring entries read as zero at once, no clearing pass

module humidity_average_hysteresis_relay (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hahr_pkg::ADC_W-1:0]     in_adc_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hahr_pkg::HUM_W-1:0]     out_humidity_avg,
  output logic                           out_relay_on,
  input  logic                           cfg_we,
  input  logic [hahr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hahr_pkg::HUM_W-1:0]     cfg_data
);

  // thresholds
  logic [hahr_pkg::HUM_W-1:0] low_thr_r;
  logic [hahr_pkg::HUM_W-1:0] high_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= hahr_pkg::LOW_THRESHOLD_RST;
      high_thr_r <= hahr_pkg::HIGH_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hahr_pkg::REG_LOW_THRESHOLD:  low_thr_r  <= cfg_data;
        hahr_pkg::REG_HIGH_THRESHOLD: high_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and pipeline advance
  logic v1_r, v2_r, v3_r, v4_r;
  logic out_valid_r;
  logic adv;
  logic accept;

  // everything moves unless the last stage is blocked on a full output register
  assign adv      = !v4_r || !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // stage 1: scaled sample, ring read issued, write slot
  logic [hahr_pkg::SLOT_W-1:0] slot_r;
  logic [hahr_pkg::SLOT_W-1:0] slot_nxt;
  logic [hahr_pkg::SLOT_W-1:0] slot1_r;
  logic [hahr_pkg::X_W-1:0]    x1_r;
  logic                        fwd1_r;
  logic [hahr_pkg::X_W-1:0]    x_nxt;

  assign x_nxt = hahr_pkg::X_W'(in_adc_sample) * hahr_pkg::X_W'(hahr_pkg::CAL_MUL)
               + hahr_pkg::X_W'(hahr_pkg::CAL_ADD);

  assign slot_nxt = (slot_r == hahr_pkg::SLOT_W'(hahr_pkg::RING_DEPTH - 1))
                  ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (accept) begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1_r    <= x_nxt;
      slot1_r <= slot_r;
      // entry still in flight to the ram: take it from stage 2 instead
      fwd1_r  <= v1_r && (slot1_r == slot_r);
    end
  end

  // stage 1 -> 2: calibrated value, old entry, ring write
  logic [hahr_pkg::CAL_PW-1:0] cal_prod;
  logic [hahr_pkg::HUM_W-1:0]  h1;
  logic [hahr_pkg::HUM_W-1:0]  ring_rd;
  logic [hahr_pkg::HUM_W-1:0]  old1;
  logic [hahr_pkg::HUM_W-1:0]  h2_r;
  logic [hahr_pkg::HUM_W-1:0]  old2_r;
  hahr_pkg::ring_wr_t          ring_wr;

  assign cal_prod = hahr_pkg::CAL_PW'(x1_r) * hahr_pkg::CAL_PW'(hahr_pkg::CAL_RECIP);
  assign h1       = cal_prod[hahr_pkg::CAL_SHIFT +: hahr_pkg::HUM_W];
  assign old1     = fwd1_r ? h2_r : ring_rd;

  assign ring_wr.en   = v1_r && adv;
  assign ring_wr.slot = slot1_r;
  assign ring_wr.data = h1;

  hahr_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_slot (slot_r),
    .rd_data (ring_rd),
    .wr      (ring_wr)
  );

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      h2_r   <= h1;
      old2_r <= old1;
    end
  end

  // stage 2 -> 3: running total
  logic [hahr_pkg::TOTAL_W-1:0] total_r;
  logic [hahr_pkg::TOTAL_W-1:0] total_nxt;
  logic [hahr_pkg::TOTAL_W-1:0] tot3_r;

  assign total_nxt = total_r - hahr_pkg::TOTAL_W'(old2_r) + hahr_pkg::TOTAL_W'(h2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (adv && v2_r) begin
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      tot3_r <= total_nxt;
    end
  end

  // stage 3 -> 4: mean by reciprocal, low bits kept
  logic [hahr_pkg::AVG_PW-1:0] avg_prod;
  logic [hahr_pkg::HUM_W-1:0]  avg4_r;

  assign avg_prod = hahr_pkg::AVG_PW'(tot3_r) * hahr_pkg::AVG_PW'(hahr_pkg::AVG_RECIP);

  always_ff @(posedge clk) begin
    if (adv && v3_r) begin
      avg4_r <= avg_prod[hahr_pkg::AVG_SHIFT +: hahr_pkg::HUM_W];
    end
  end

  // stage 4 -> out: hysteresis, switch-off test wins when thresholds cross
  logic relay_r;
  logic relay_nxt;

  always_comb begin
    relay_nxt = relay_r;
    if (avg4_r > high_thr_r) begin
      relay_nxt = 1'b1;
    end
    if (avg4_r < low_thr_r) begin
      relay_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r <= 1'b0;
    end else if (adv && v4_r) begin
      relay_r <= relay_nxt;
    end
  end

  logic [hahr_pkg::HUM_W-1:0] out_avg_r;
  logic                       out_relay_r;

  always_ff @(posedge clk) begin
    if (adv && v4_r) begin
      out_avg_r   <= avg4_r;
      out_relay_r <= relay_nxt;
    end
  end

  // stage valids and output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v1_r <= in_valid;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
      end
      if (adv && v4_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_humidity_avg = out_avg_r;
  assign out_relay_on     = out_relay_r;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // depth of the averaging window as the block is meant to have it
  localparam int RING_LEN = 50;

  typedef struct packed {
    logic [hahr_pkg::HUM_W-1:0] humidity_avg;
    logic                       relay_on;
  } reading_t;

  logic                           clk           = 1'b0;
  logic                           rst_n         = 1'b0;
  logic                           in_valid      = 1'b0;
  logic                           in_ready;
  logic [hahr_pkg::ADC_W-1:0]     in_adc_sample = '0;
  logic                           out_valid;
  logic                           out_ready     = 1'b0;
  logic [hahr_pkg::HUM_W-1:0]     out_humidity_avg;
  logic                           out_relay_on;
  logic                           cfg_we        = 1'b0;
  logic [hahr_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [hahr_pkg::HUM_W-1:0]     cfg_data      = '0;

  // local copy of the controller state, reset values as after rst_n
  logic [hahr_pkg::HUM_W-1:0]   hum_ring [RING_LEN];
  int                           ring_slot   = 0;
  logic [hahr_pkg::TOTAL_W-1:0] hum_total   = '0;
  logic                         relay_state = 1'b0;
  logic [hahr_pkg::HUM_W-1:0]   low_thr     = 7'd25;
  logic [hahr_pkg::HUM_W-1:0]   high_thr    = 7'd50;

  reading_t expected_readings[$];
  int       mismatch_count  = 0;

  // idling controls: random bursts on each side, plus one long output hold-off
  bit source_gaps     = 1'b1;
  bit sink_gaps       = 1'b1;
  int hold_off_cycles = 0;

  always #6 clk = ~clk;

  humidity_average_hysteresis_relay i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_humidity_avg (out_humidity_avg),
    .out_relay_on     (out_relay_on),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    foreach (hum_ring[i]) hum_ring[i] = '0;
  end

  // calibrate one sample, push it through the ring and update the relay
  function automatic reading_t predict_reading(input logic [hahr_pkg::ADC_W-1:0] adc);
    int unsigned hum;
    int unsigned mean;
    reading_t    r;
    hum = (36 * int'(adc) + 730) / 301;
    // 13-bit running sum, so the wrap matches the hardware register
    hum_total = hum_total - hum_ring[ring_slot] + hum[hahr_pkg::HUM_W-1:0];
    hum_ring[ring_slot] = hum[hahr_pkg::HUM_W-1:0];
    ring_slot = (ring_slot + 1) % RING_LEN;
    mean = hum_total / RING_LEN;
    // switch-on test first, so with crossed thresholds the switch-off test wins
    if (mean > high_thr) relay_state = 1'b1;
    if (mean < low_thr) relay_state = 1'b0;
    r.humidity_avg = mean[hahr_pkg::HUM_W-1:0];
    r.relay_on     = relay_state;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // offer one sample beat and hold it until it is taken
  task automatic send_sample(input logic [hahr_pkg::ADC_W-1:0] adc);
    int gap;
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= adc;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_readings.push_back(predict_reading(adc));
  endtask

  // drop valid and wait until every outstanding reading has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // thresholds are only changed with the pipeline empty
  task automatic set_thresholds(input logic [hahr_pkg::HUM_W-1:0] low,
                                input logic [hahr_pkg::HUM_W-1:0] high);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= hahr_pkg::REG_LOW_THRESHOLD;
    cfg_data  <= low;
    @(posedge clk);
    low_thr   = low;
    cfg_index <= hahr_pkg::REG_HIGH_THRESHOLD;
    cfg_data  <= high;
    @(posedge clk);
    high_thr  = high;
    cfg_we    <= 1'b0;
  endtask

  // samples that dwell around a level for a while, then jump; some pure noise mixed in
  // so the mean sweeps across the thresholds in both directions
  task automatic drive_level_walk(input int count);
    int level;
    int run;
    int jitter;
    int adc;
    level = 0;
    run   = 0;
    repeat (count) begin
      if (run == 0) begin
        level = $urandom_range(0, 1023);
        run   = $urandom_range(20, 80);
      end
      run--;
      if ($urandom_range(0, 4) == 0) begin
        adc = $urandom_range(0, 1023);
      end else begin
        jitter = $urandom_range(0, 64);
        adc    = level + jitter - 32;
      end
      if (adc < 0) adc = 0;
      if (adc > 1023) adc = 1023;
      send_sample(adc[hahr_pkg::ADC_W-1:0]);
    end
  endtask

  // calibration ends and the two points the line is fitted through; ring is
  // still filling, so this also covers the start of warm-up
  task automatic test_calibration_points();
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd264);
    send_sample(10'd565);
    send_sample(10'h2aa);
    send_sample(10'h155);
    send_sample(10'd1);
    send_sample(10'd512);
  endtask

  // mean climbs slowly from zero while the ring fills with top-scale samples
  task automatic test_warm_up();
    repeat (9) send_sample(10'd1023);
  endtask

  // thresholds at the register limits, equal and crossed
  task automatic test_threshold_extremes();
    set_thresholds(7'd0, 7'd0);       // any non-zero mean switches on
    repeat (2) send_sample(10'd1023);
    set_thresholds(7'd127, 7'd0);     // crossed: on then off in the same beat, ends off
    repeat (2) send_sample(10'd1023);
    set_thresholds(7'd0, 7'd0);
    send_sample(10'd700);
    set_thresholds(7'd0, 7'd127);     // neither test can fire, relay holds
    repeat (2) send_sample(10'd0);
    set_thresholds(7'd127, 7'd127);   // everything is below low, relay off
    send_sample(10'd300);
  endtask

  // several threshold settings, each with a long walk of sample levels
  task automatic test_hysteresis_phases();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_thresholds(7'd25, 7'd50);
        1: set_thresholds(7'd10, 7'd90);
        2: set_thresholds(7'd90, 7'd10);
        3: set_thresholds(7'd60, 7'd60);
        4: set_thresholds(7'd0, 7'd127);
        default: set_thresholds(hahr_pkg::HUM_W'($urandom_range(10, 90)),
                                hahr_pkg::HUM_W'($urandom_range(10, 90)));
      endcase
      drive_level_walk(130);
    end
  endtask

  // long output hold-off with the source running flat out, so the pipeline
  // fills and in_ready has to drop
  task automatic test_output_backpressure();
    set_thresholds(7'd30, 7'd45);
    source_gaps     = 1'b0;
    hold_off_cycles = 60;
    repeat (30) send_sample(hahr_pkg::ADC_W'($urandom_range(0, 1023)));
    source_gaps = 1'b1;
  endtask

  // last stretch with no idling on either side
  task automatic test_full_rate();
    set_thresholds(hahr_pkg::HUM_W'($urandom_range(10, 90)),
                   hahr_pkg::HUM_W'($urandom_range(10, 90)));
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    drive_level_walk(90);
  endtask

  // result side ready: random stall bursts, or the long hold-off when asked
  initial begin : result_sink
    int span;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        span            = hold_off_cycles;
        hold_off_cycles = 0;
        out_ready <= 1'b0;
        repeat (span) @(posedge clk);
        out_ready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        span = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (span) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // every result beat is matched against the oldest queued reading
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result beat", int'(out_humidity_avg), -1);
      end else begin
        want = expected_readings.pop_front();
        if (out_humidity_avg !== want.humidity_avg)
          report_mismatch("humidity_avg", int'(out_humidity_avg), int'(want.humidity_avg));
        if (out_relay_on !== want.relay_on)
          report_mismatch("relay_on", int'(out_relay_on), int'(want.relay_on));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_calibration_points();
    test_warm_up();
    test_threshold_extremes();
    test_hysteresis_phases();
    test_output_backpressure();
    test_full_rate();
    settle();
    // run on past the last result to catch stray beats
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // 5 ms is well above the worst case, with every gap and stall at its longest
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
